@@ src/fst_pkg.sv @@
package fst_pkg;

    localparam int LENGTH_BITS_DEF = 24;

    localparam logic [7:0] CH_ESCAPE  = 8'h3F;
    localparam logic [7:0] CH_SEGMENT = 8'h27;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic [1:0] EC_NONE       = 2'd0;
    localparam logic [1:0] EC_STANDALONE = 2'd1;
    localparam logic [1:0] EC_IN_GROUP   = 2'd2;

    localparam logic [1:0] GC_NONE   = 2'd0;
    localparam logic [1:0] GC_HEADER = 2'd1;
    localparam logic [1:0] GC_DATA   = 2'd2;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       message_end;
    } t_in_word;

    typedef struct packed {
        logic       value_valid;
        logic [7:0] value_byte;
        logic [1:0] element_close;
        logic [1:0] group_close;
        logic       segment_close;
    } t_out_word;

endpackage

@@ src/fst_lexer.sv @@
module fst_lexer #(
    parameter int LENGTH_BITS = fst_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  fst_pkg::t_in_word i_word,
    output fst_pkg::t_out_word o_word
);

    localparam int AW = LENGTH_BITS + 4;

    logic                   r_escape;
    logic                   r_in_group;
    logic                   r_reading_len;
    logic [LENGTH_BITS-1:0] r_len_acc;
    logic                   r_len_invalid;
    logic [LENGTH_BITS-1:0] r_raw_left;
    logic                   r_hdr_missing;

    logic                   n_escape;
    logic                   n_in_group;
    logic                   n_reading_len;
    logic [LENGTH_BITS-1:0] n_len_acc;
    logic                   n_len_invalid;
    logic [LENGTH_BITS-1:0] n_raw_left;
    logic                   n_hdr_missing;

    logic [7:0]    w_byte;
    logic [AW-1:0] w_acc_next;
    logic          w_is_digit;

    assign w_byte     = i_word.byte_in;
    assign w_is_digit = (w_byte >= fst_pkg::CH_ZERO) && (w_byte <= fst_pkg::CH_NINE);
    // acc * 10 + digit; low nibble of an ASCII digit is its value
    assign w_acc_next = (AW'(r_len_acc) << 3) + (AW'(r_len_acc) << 1) + AW'(w_byte[3:0]);

    always_comb begin
        n_escape      = r_escape;
        n_in_group    = r_in_group;
        n_reading_len = r_reading_len;
        n_len_acc     = r_len_acc;
        n_len_invalid = r_len_invalid;
        n_raw_left    = r_raw_left;
        n_hdr_missing = r_hdr_missing;
        o_word        = '0;

        if (r_escape) begin
            o_word.value_valid = 1'b1;
            o_word.value_byte  = w_byte;
            n_escape           = 1'b0;
        end else if (r_reading_len) begin
            if (w_byte == fst_pkg::CH_AT) begin
                n_reading_len = 1'b0;
                n_raw_left    = r_len_invalid ? '0 : r_len_acc;
            end else if (w_is_digit) begin
                if (!r_len_invalid) begin
                    if (w_acc_next[AW-1:LENGTH_BITS] != '0) begin
                        n_len_invalid = 1'b1;
                    end else begin
                        n_len_acc = w_acc_next[LENGTH_BITS-1:0];
                    end
                end
            end else begin
                n_len_invalid = 1'b1;
            end
        end else if (r_raw_left != '0) begin
            o_word.value_valid = 1'b1;
            o_word.value_byte  = w_byte;
            n_raw_left         = r_raw_left - LENGTH_BITS'(1);
        end else begin
            case (w_byte)
                fst_pkg::CH_ESCAPE: begin
                    n_escape = 1'b1;
                end
                fst_pkg::CH_SEGMENT: begin
                    if (r_in_group) begin
                        o_word.element_close = fst_pkg::EC_IN_GROUP;
                        o_word.group_close   = fst_pkg::GC_DATA;
                        n_in_group           = 1'b0;
                    end else begin
                        o_word.element_close = fst_pkg::EC_STANDALONE;
                    end
                    if (!r_hdr_missing) begin
                        o_word.segment_close = 1'b1;
                        n_hdr_missing        = 1'b1;
                    end
                end
                fst_pkg::CH_PLUS: begin
                    if (r_in_group) begin
                        o_word.element_close = fst_pkg::EC_IN_GROUP;
                        if (r_hdr_missing) begin
                            o_word.group_close = fst_pkg::GC_HEADER;
                            n_hdr_missing      = 1'b0;
                        end else begin
                            o_word.group_close = fst_pkg::GC_DATA;
                        end
                    end else begin
                        o_word.element_close = fst_pkg::EC_STANDALONE;
                    end
                    n_in_group = 1'b0;
                end
                fst_pkg::CH_COLON: begin
                    n_in_group           = 1'b1;
                    o_word.element_close = fst_pkg::EC_IN_GROUP;
                end
                fst_pkg::CH_AT: begin
                    n_reading_len = 1'b1;
                    n_len_acc     = '0;
                    n_len_invalid = 1'b0;
                    n_raw_left    = '0;
                end
                default: begin
                    o_word.value_valid = 1'b1;
                    o_word.value_byte  = w_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_word.message_end)) begin
            r_escape      <= 1'b0;
            r_in_group    <= 1'b0;
            r_reading_len <= 1'b0;
            r_len_acc     <= '0;
            r_len_invalid <= 1'b0;
            r_raw_left    <= '0;
            r_hdr_missing <= 1'b1;
        end else if (i_fire) begin
            r_escape      <= n_escape;
            r_in_group    <= n_in_group;
            r_reading_len <= n_reading_len;
            r_len_acc     <= n_len_acc;
            r_len_invalid <= n_len_invalid;
            r_raw_left    <= n_raw_left;
            r_hdr_missing <= n_hdr_missing;
        end
    end

    a_len_no_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reading_len |-> (r_raw_left == '0))
        else $error("raw count nonzero while reading length");

    a_esc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> (!r_reading_len && (r_raw_left == '0)))
        else $error("escape pending during length or raw run");

    a_grp_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.group_close != fst_pkg::GC_NONE) |->
            (o_word.element_close == fst_pkg::EC_IN_GROUP))
        else $error("group close without element close");

endmodule

@@ src/fints_syntax_tokenizer.sv @@
// Pipeline: input register, then result register. Throughput: one word per
// cycle while the output is not stalled; the state update is one pass through
// the lexer logic between the input register and the result register.
// Reset: synchronous active-low i_rst_n clears the valid flags of both pipeline
// registers and the lexer state, which also resets after a message_end word.
module fints_syntax_tokenizer #(
    parameter int LENGTH_BITS = fst_pkg::LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  fst_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output fst_pkg::t_out_word o_out_word
);

    logic               r_in_valid;
    fst_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    fst_pkg::t_out_word r_out_word;

    logic               w_advance;
    fst_pkg::t_out_word w_lex_word;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    fst_lexer #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_lexer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_advance),
        .i_word (r_in_word),
        .o_word (w_lex_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_advance) begin
            r_out_word <= w_lex_word;
        end
    end

    a_seg_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.segment_close) |->
            (o_out_word.element_close != fst_pkg::EC_NONE))
        else $error("segment close without element close");

    a_value_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.value_valid) |->
            ((o_out_word.element_close == fst_pkg::EC_NONE) &&
             (o_out_word.group_close == fst_pkg::GC_NONE)))
        else $error("value byte together with a close event");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_word)))
        else $error("stalled input word lost");

endmodule
